// ===== hw/rtl/pdt_pkg.sv =====
// ----------------------------------------------------------------------------
// pdt_pkg
// Shared request codes, decoded operation type and queue word layout for the
// periodic task dispatcher.
// ----------------------------------------------------------------------------
package pdt_pkg;

  // request codes on req_type
  localparam logic [2:0] REQ_TICK     = 3'd0;
  localparam logic [2:0] REQ_ADD      = 3'd1;
  localparam logic [2:0] REQ_REMOVE   = 3'd2;
  localparam logic [2:0] REQ_DISPATCH = 3'd3;
  localparam logic [2:0] REQ_SETTIME  = 3'd4;

  // decoded operation handed from front to back
  typedef enum logic [2:0] {
    OP_TICK,
    OP_ADD,
    OP_REMOVE,
    OP_DISPATCH,
    OP_SETTIME,
    OP_BAD
  } op_t;

  // one queued word
  typedef struct packed {
    op_t         op;
    logic        slot_ok;
    logic [2:0]  slot;
    logic [15:0] period;
    logic [15:0] start;
    logic [31:0] time_val;
  } pdt_item_t;

  // queue to back-end handshake
  typedef struct packed {
    logic      valid;
    pdt_item_t item;
  } pdt_q_t;

endpackage

// ===== hw/rtl/pdt_front.sv =====
// ----------------------------------------------------------------------------
// pdt_front
// Accepts request words, decodes the request code and checks the slot range.
// ----------------------------------------------------------------------------
module pdt_front #(
  parameter int SLOT_COUNT = 8
) (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        req_type,
  input  logic [2:0]        task_slot,
  input  logic [15:0]       task_period,
  input  logic [15:0]       start_countdown,
  input  logic [31:0]       time_value,
  input  logic              q_full,
  output logic              q_push,
  output pdt_pkg::pdt_item_t q_word
);
  import pdt_pkg::*;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // classify the request
  always_comb begin
    q_word.slot     = task_slot;
    q_word.slot_ok  = ({29'd0, task_slot} < 32'(SLOT_COUNT));
    q_word.period   = task_period;
    q_word.start    = start_countdown;
    q_word.time_val = time_value;
    unique case (req_type)
      REQ_TICK:     q_word.op = OP_TICK;
      REQ_ADD:      q_word.op = OP_ADD;
      REQ_REMOVE:   q_word.op = OP_REMOVE;
      REQ_DISPATCH: q_word.op = OP_DISPATCH;
      REQ_SETTIME:  q_word.op = OP_SETTIME;
      default:      q_word.op = OP_BAD;
    endcase
  end

endmodule

// ===== hw/rtl/pdt_queue.sv =====
// ----------------------------------------------------------------------------
// pdt_queue
// Two-entry queue between the decode front and the list engine.
// ----------------------------------------------------------------------------
module pdt_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  pdt_pkg::pdt_item_t push_word,
  output logic               full,
  input  logic               pop,
  output pdt_pkg::pdt_q_t    head
);
  import pdt_pkg::*;

  pdt_item_t  entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full       = (fill == 2'd2);
  assign head.valid = (fill != 2'd0);
  assign head.item  = entry[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_word;
  end

endmodule

// ===== hw/rtl/pdt_engine.sv =====
// ----------------------------------------------------------------------------
// pdt_engine
// List engine: walks the task list slot by slot for ticks,
// dispatches and removals, and holds the result word register.
// ----------------------------------------------------------------------------
module pdt_engine #(
  parameter int SLOT_COUNT = 8,
  parameter int COUNT_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  pdt_pkg::pdt_q_t q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            accepted,
  output logic            task_found,
  output logic [2:0]      run_slot,
  output logic [31:0]     time_now
);
  import pdt_pkg::*;

  localparam int SW = $clog2(SLOT_COUNT);
  localparam int NW = $clog2(SLOT_COUNT + 1);
  localparam int CW = COUNT_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_T_RD, S_T_UP, S_D_RD, S_D_CHK,
    S_U_RD, S_U_NX, S_U_WRD, S_U_WCHK, S_U_FIN, S_RES
  } state_t;

  state_t state;

  // per-slot flags and list pointers
  logic [SLOT_COUNT-1:0] listed;
  logic [SLOT_COUNT-1:0] ready;
  logic [SLOT_COUNT-1:0] has_succ;
  logic [SW-1:0]         head_slot;
  logic [SW-1:0]         tail_slot;
  logic [SW-1:0]         cursor_slot;
  logic                  cursor_end;
  logic [31:0]           tick_count;
  logic [NW-1:0]         list_num;

  // walk registers
  logic [SW-1:0] walk;
  logic [SW-1:0] target;
  logic [SW-1:0] nx;
  logic          has_nx;
  logic [NW-1:0] steps;
  logic          res_acc;
  logic          res_found;
  logic [SW-1:0] res_run;

  // memories
  logic [SW-1:0] nl_mem  [SLOT_COUNT];
  logic [CW-1:0] cd_mem  [SLOT_COUNT];
  logic [CW-1:0] per_mem [SLOT_COUNT];
  logic [SW-1:0] rd_nl;
  logic [CW-1:0] rd_cd;
  logic [CW-1:0] rd_per;
  logic [SW-1:0] mem_addr;
  logic          nl_we, cd_we, per_we;
  logic [SW-1:0] nl_wa, cd_wa;
  logic [SW-1:0] nl_wd;
  logic [CW-1:0] cd_wd;

  // incoming word fields
  pdt_item_t     it;
  logic [SW-1:0] it_slot;
  logic          add_ok;
  logic          empty;
  logic [CW-1:0] cd_dec;
  logic          out_free;

  assign it       = q_head.item;
  assign it_slot  = SW'(it.slot);
  assign empty    = !listed[head_slot];
  assign add_ok   = it.slot_ok && !listed[it_slot];
  assign q_pop    = (state == S_IDLE) && q_head.valid;
  assign cd_dec   = (rd_cd != '0) ? rd_cd - CW'(1) : rd_cd;
  assign out_free = !out_valid || !out_stall;

  // read address and write ports
  always_comb begin
    mem_addr = walk;
    nl_we  = 1'b0;
    nl_wa  = tail_slot;
    nl_wd  = it_slot;
    cd_we  = 1'b0;
    cd_wa  = it_slot;
    cd_wd  = CW'(it.start);
    per_we = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (q_head.valid && it.op == OP_ADD && add_ok) begin
          nl_we  = !empty;
          cd_we  = 1'b1;
          per_we = 1'b1;
        end
      end
      S_U_RD: mem_addr = target;
      S_T_UP: begin
        cd_we = 1'b1;
        cd_wa = walk;
        cd_wd = (cd_dec == '0) ? rd_per : cd_dec;
      end
      S_U_WCHK: begin
        nl_we = (rd_nl == target) && has_nx;
        nl_wa = walk;
        nl_wd = nx;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (nl_we)  nl_mem[nl_wa]   <= nl_wd;
    if (cd_we)  cd_mem[cd_wa]   <= cd_wd;
    if (per_we) per_mem[it_slot] <= CW'(it.period);
    rd_nl  <= nl_mem[mem_addr];
    rd_cd  <= cd_mem[mem_addr];
    rd_per <= per_mem[mem_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      listed      <= '0;
      ready       <= '0;
      has_succ    <= '0;
      head_slot   <= '0;
      tail_slot   <= '0;
      cursor_slot <= '0;
      cursor_end  <= 1'b1;
      tick_count  <= '0;
      list_num    <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_RES) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_head.valid) begin
            res_found <= 1'b0;
            res_run   <= '0;
            steps     <= '0;
            unique case (it.op)
              OP_TICK: begin
                res_acc    <= 1'b1;
                tick_count <= tick_count + 32'd1;
                walk       <= head_slot;
                state      <= empty ? S_RES : S_T_RD;
              end
              OP_ADD: begin
                res_acc <= add_ok;
                state   <= S_RES;
                // free slots never carry a successor flag
                if (add_ok) begin
                  if (empty) head_slot <= it_slot;
                  else has_succ[tail_slot] <= 1'b1;
                  tail_slot        <= it_slot;
                  listed[it_slot]  <= 1'b1;
                  ready[it_slot]   <= 1'b0;
                  list_num         <= list_num + NW'(1);
                end
              end
              OP_REMOVE: begin
                target <= it_slot;
                if (it.slot_ok && listed[it_slot]) begin
                  res_acc <= 1'b1;
                  state   <= S_U_RD;
                end else begin
                  res_acc <= 1'b0;
                  state   <= S_RES;
                end
              end
              OP_DISPATCH: begin
                res_acc <= 1'b1;
                walk <= (cursor_end || !listed[cursor_slot]) ? head_slot : cursor_slot;
                state <= (list_num != '0 && !empty) ? S_D_RD : S_RES;
              end
              OP_SETTIME: begin
                res_acc    <= 1'b1;
                tick_count <= it.time_val;
                state      <= S_RES;
              end
              default: begin
                res_acc <= 1'b0;
                state   <= S_RES;
              end
            endcase
          end
        end
        // tick walk
        S_T_RD: state <= S_T_UP;
        S_T_UP: begin
          if (cd_dec == '0) ready[walk] <= 1'b1;
          steps <= steps + NW'(1);
          walk  <= rd_nl;
          if (has_succ[walk] && (steps + NW'(1)) < NW'(SLOT_COUNT) && listed[rd_nl])
            state <= S_T_RD;
          else
            state <= S_RES;
        end
        // dispatch walk
        S_D_RD: state <= S_D_CHK;
        S_D_CHK: begin
          if (listed[walk] && ready[walk]) begin
            res_found <= 1'b1;
            res_run   <= walk;
            target    <= walk;
            if (has_succ[walk]) begin
              cursor_slot <= rd_nl;
              cursor_end  <= 1'b0;
            end else begin
              cursor_end <= 1'b1;
            end
            if (rd_per == '0) begin
              state <= S_U_RD;
            end else begin
              ready[walk] <= 1'b0;
              state       <= S_RES;
            end
          end else begin
            steps <= steps + NW'(1);
            walk  <= has_succ[walk] ? rd_nl : head_slot;
            if ((steps + NW'(1)) < list_num) state <= S_D_RD;
            else state <= S_RES;
          end
        end
        // unlink
        S_U_RD: state <= S_U_NX;
        S_U_NX: begin
          has_nx <= has_succ[target];
          nx     <= rd_nl;
          steps  <= '0;
          walk   <= head_slot;
          if (!cursor_end && cursor_slot == target) begin
            if (has_succ[target]) cursor_slot <= rd_nl;
            else cursor_end <= 1'b1;
          end
          if (head_slot == target) begin
            if (has_succ[target]) head_slot <= rd_nl;
            state <= S_U_FIN;
          end else begin
            state <= S_U_WRD;
          end
        end
        S_U_WRD: state <= has_succ[walk] ? S_U_WCHK : S_U_FIN;
        S_U_WCHK: begin
          if (rd_nl == target) begin
            if (!has_nx) begin
              has_succ[walk] <= 1'b0;
              tail_slot      <= walk;
            end
            state <= S_U_FIN;
          end else begin
            walk  <= rd_nl;
            steps <= steps + NW'(1);
            state <= ((steps + NW'(1)) < NW'(SLOT_COUNT)) ? S_U_WRD : S_U_FIN;
          end
        end
        S_U_FIN: begin
          listed[target]   <= 1'b0;
          ready[target]    <= 1'b0;
          has_succ[target] <= 1'b0;
          list_num         <= list_num - NW'(1);
          if (head_slot == target || !listed[head_slot]) cursor_end <= 1'b1;
          state <= S_RES;
        end
        // result word
        S_RES: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            accepted   <= res_acc;
            task_found <= res_found;
            run_slot   <= 3'(res_run);
            time_now   <= tick_count;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/periodic_task_dispatcher.sv =====
// ----------------------------------------------------------------------------
// periodic_task_dispatcher
// Cooperative periodic task scheduler over a linked list of task slots.
//
//   channel | direction | handshake          | fields
//   in      | input     | in_valid/in_stall  | req_type task_slot task_period
//           |           |                    | start_countdown time_value
//   out     | output    | out_valid/out_stall| accepted task_found run_slot
//           |           |                    | time_now
//
// Add, set time and refused requests go straight to the result word. A tick
// walks every listed slot, a dispatch walks from the cursor up to the first
// ready slot, plus an unlink walk when a run-once task is unlinked, and a
// remove does an unlink walk; the list walk reads each slot in turn from the
// link, countdown and period memories. Reset is synchronous and empties the
// list; no clearing pass. A two-word queue lets input words land while the
// engine works or the result word is stalled.
// ----------------------------------------------------------------------------
module periodic_task_dispatcher #(
  parameter int SLOT_COUNT = 8,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic [2:0]  task_slot,
  input  logic [15:0] task_period,
  input  logic [15:0] start_countdown,
  input  logic [31:0] time_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        accepted,
  output logic        task_found,
  output logic [2:0]  run_slot,
  output logic [31:0] time_now
);
  import pdt_pkg::*;

  logic      q_full;
  logic      q_push;
  logic      q_pop;
  pdt_item_t q_word;
  pdt_q_t    q_head;

  pdt_front #(.SLOT_COUNT(SLOT_COUNT)) u_front (
    .in_valid, .in_stall, .req_type, .task_slot, .task_period,
    .start_countdown, .time_value, .q_full, .q_push, .q_word
  );

  pdt_queue u_queue (
    .clk, .rst, .push(q_push), .push_word(q_word), .full(q_full),
    .pop(q_pop), .head(q_head)
  );

  pdt_engine #(.SLOT_COUNT(SLOT_COUNT), .COUNT_BITS(COUNT_BITS)) u_engine (
    .clk, .rst, .q_head, .q_pop, .out_valid, .out_stall, .accepted,
    .task_found, .run_slot, .time_now
  );

endmodule

// ===== hw/rtl/pdt_checker.sv =====
// ----------------------------------------------------------------------------
// pdt_port_checks
// Port-level checks for the periodic task dispatcher.
// ----------------------------------------------------------------------------
module pdt_port_checks (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        accepted,
  input logic        task_found,
  input logic [2:0]  run_slot,
  input logic [31:0] time_now
);

  // no result word right after reset
  a_reset_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid after reset");

  // a stalled result word stays
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(time_now))
    else $error("stalled result word dropped or changed");

  // run_slot is zero unless a task was found
  a_run_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !task_found |-> run_slot == 3'd0)
    else $error("run_slot nonzero without a found task");

  // a found task implies the dispatch was accepted
  a_found_acc: assert property (@(posedge clk) disable iff (rst)
    out_valid && task_found |-> accepted)
    else $error("task found on a refused request");

endmodule

bind periodic_task_dispatcher pdt_port_checks u_pdt_checker (.*);

// ===== sim/pdt_checker.sv =====
// ----------------------------------------------------------------------------
// pdt_checker
// Watches both channels of the periodic task dispatcher. It keeps its own
// copy of the task list, predicts the result word of every request taken in
// and compares it with the words that come out, in order.
// ----------------------------------------------------------------------------
module pdt_checker
  import pdt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic [2:0]  task_slot,
  input  logic [15:0] task_period,
  input  logic [15:0] start_countdown,
  input  logic [31:0] time_value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        accepted,
  input  logic        task_found,
  input  logic [2:0]  run_slot,
  input  logic [31:0] time_now,
  output int          errors,
  output int          pending
);

  localparam int SLOTS = 8;

  typedef struct packed {
    logic        acc;
    logic        found;
    logic [2:0]  slot;
    logic [31:0] now;
  } result_t;

  result_t expected_q[$];

  // shadow of the task list
  logic        listed[SLOTS];
  logic        has_nx[SLOTS];
  logic        rdy[SLOTS];
  logic [2:0]  link[SLOTS];
  logic [15:0] cnt[SLOTS];
  logic [15:0] per[SLOTS];
  logic [2:0]  head, tail, cur;
  logic        cur_end;
  logic [31:0] ticks;

  assign pending = expected_q.size();

  function automatic bit list_empty();
    return !listed[head];
  endfunction

  function automatic int listed_count();
    int c;
    c = 0;
    for (int i = 0; i < SLOTS; i++) if (listed[i]) c++;
    return c;
  endfunction

  // unlink a listed slot from anywhere in the list, moving the cursor off it
  task automatic unlink_task(input logic [2:0] s);
    logic [2:0] p;
    logic [2:0] nx;
    logic       has;
    nx = link[s];
    has = has_nx[s];
    p = head;
    if (!cur_end && cur == s) begin
      if (has) cur = nx;
      else cur_end = 1'b1;
    end
    if (head == s) begin
      if (has) head = nx;
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (!has_nx[p]) break;
        if (link[p] == s) begin
          if (has) link[p] = nx;
          else begin
            has_nx[p] = 1'b0;
            tail = p;
          end
          break;
        end
        p = link[p];
      end
    end
    listed[s] = 1'b0;
    rdy[s] = 1'b0;
    has_nx[s] = 1'b0;
    if (list_empty()) cur_end = 1'b1;
  endtask

  task automatic tick_task();
    logic [2:0] p;
    p = head;
    ticks = ticks + 32'd1;
    if (!list_empty()) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (!listed[p]) break;
        if (cnt[p] != 0) cnt[p] = cnt[p] - 16'd1;
        if (cnt[p] == 0) begin
          cnt[p] = per[p];
          rdy[p] = 1'b1;
        end
        if (!has_nx[p]) break;
        p = link[p];
      end
    end
  endtask

  task automatic add_task(input logic [2:0] s, input logic [15:0] pd, input logic [15:0] st,
                          output logic ok);
    ok = 1'b0;
    if (!listed[s]) begin
      if (list_empty()) head = s;
      else begin
        link[tail] = s;
        has_nx[tail] = 1'b1;
      end
      tail = s;
      listed[s] = 1'b1;
      has_nx[s] = 1'b0;
      rdy[s] = 1'b0;
      per[s] = pd;
      cnt[s] = st;
      ok = 1'b1;
    end
  endtask

  // round-robin search for a ready task, one pass at most
  task automatic dispatch_task(output logic found, output logic [2:0] slot);
    int n;
    logic [2:0] pos;
    found = 1'b0;
    slot = '0;
    n = listed_count();
    if (n != 0 && !list_empty()) begin
      pos = (cur_end || !listed[cur]) ? head : cur;
      for (int i = 0; i < n; i++) begin
        if (listed[pos] && rdy[pos]) begin
          if (has_nx[pos]) begin
            cur = link[pos];
            cur_end = 1'b0;
          end else cur_end = 1'b1;
          if (per[pos] == 0) unlink_task(pos);
          else rdy[pos] = 1'b0;
          found = 1'b1;
          slot = pos;
          break;
        end
        pos = has_nx[pos] ? link[pos] : head;
      end
    end
  endtask

  task automatic predict_word();
    result_t r;
    logic ok;
    r = '0;
    case (req_type)
      REQ_TICK: begin
        tick_task();
        r.acc = 1'b1;
      end
      REQ_ADD: begin
        add_task(task_slot, task_period, start_countdown, ok);
        r.acc = ok;
      end
      REQ_REMOVE: begin
        if (listed[task_slot]) begin
          unlink_task(task_slot);
          r.acc = 1'b1;
        end
      end
      REQ_DISPATCH: begin
        dispatch_task(r.found, r.slot);
        r.acc = 1'b1;
      end
      REQ_SETTIME: begin
        ticks = time_value;
        r.acc = 1'b1;
      end
      default: ;
    endcase
    r.now = ticks;
    expected_q.push_back(r);
  endtask

  task automatic compare_word();
    result_t e;
    if (expected_q.size() == 0) begin
      $display("%0t: result word with none expected (acc %0d found %0d slot %0d now %0h)",
               $time, accepted, task_found, run_slot, time_now);
      errors++;
    end else begin
      e = expected_q.pop_front();
      if (accepted !== e.acc) begin
        $display("%0t: accepted expected %0d actual %0d", $time, e.acc, accepted);
        errors++;
      end
      if (task_found !== e.found) begin
        $display("%0t: task_found expected %0d actual %0d", $time, e.found, task_found);
        errors++;
      end
      if (run_slot !== e.slot) begin
        $display("%0t: run_slot expected %0d actual %0d", $time, e.slot, run_slot);
        errors++;
      end
      if (time_now !== e.now) begin
        $display("%0t: time_now expected %0h actual %0h", $time, e.now, time_now);
        errors++;
      end
    end
  endtask

  initial errors = 0;

  // results are popped before the new request is predicted: a word leaving
  // at this edge always belongs to an earlier request
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        listed[i] = 1'b0;
        has_nx[i] = 1'b0;
        rdy[i] = 1'b0;
        link[i] = '0;
        cnt[i] = '0;
        per[i] = '0;
      end
      head = '0;
      tail = '0;
      cur = '0;
      cur_end = 1'b1;
      ticks = '0;
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) compare_word();
      if (in_valid && !in_stall) predict_word();
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the periodic task dispatcher: a directed opening
// over the special cases of the task list, then random request streams with
// random gaps and output stalls. The checker beside the block does the
// prediction and comparison.
// ----------------------------------------------------------------------------
module tb_top;
  import pdt_pkg::*;

  localparam logic [2:0] REQ_UNUSED5 = 3'd5;
  localparam logic [2:0] REQ_UNUSED6 = 3'd6;
  localparam logic [2:0] REQ_UNUSED7 = 3'd7;
  localparam int RANDOM_WORDS = 750;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  req_type = '0;
  logic [2:0]  task_slot = '0;
  logic [15:0] task_period = '0;
  logic [15:0] start_countdown = '0;
  logic [31:0] time_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        accepted;
  logic        task_found;
  logic [2:0]  run_slot;
  logic [31:0] time_now;
  int          errors;
  int          pending;
  int          cycles = 0;
  logic        calm = 1'b0;
  int          stall_left = 0;

  always #5 clk = ~clk;

  periodic_task_dispatcher u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .task_slot(task_slot), .task_period(task_period),
    .start_countdown(start_countdown), .time_value(time_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .accepted(accepted), .task_found(task_found), .run_slot(run_slot),
    .time_now(time_now)
  );

  pdt_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .task_slot(task_slot), .task_period(task_period),
    .start_countdown(start_countdown), .time_value(time_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .accepted(accepted), .task_found(task_found), .run_slot(run_slot),
    .time_now(time_now),
    .errors(errors), .pending(pending)
  );

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("periodic_task_dispatcher verification failed");
      $finish;
    end
  end

  // calm stretches with no gaps and no stalls
  always @(posedge clk) if ($urandom_range(0, 199) == 0) calm <= ~calm;

  // output stall: a fresh hold count per result word
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      if (calm) begin
        stall_left <= 0;
        out_stall <= 1'b0;
      end else begin
        stall_left <= int'($urandom_range(0, 8));
        out_stall <= 1'b0;
      end
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else out_stall <= 1'b0;
  end

  // one request word: random gap, then hold until taken
  task automatic send_word(input logic [2:0] rq, input logic [2:0] s, input logic [15:0] pd,
                           input logic [15:0] st, input logic [31:0] tv);
    int gap;
    logic taken;
    gap = calm ? 0 : int'($urandom_range(0, 8));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rq;
    task_slot <= s;
    task_period <= pd;
    start_countdown <= st;
    time_value <= tv;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic random_word();
    int pick;
    logic [2:0] rq;
    logic [15:0] pd, st;
    pick = int'($urandom_range(0, 99));
    pd = 16'($urandom);
    st = 16'($urandom);
    // mostly short periods so tasks become ready often
    if ($urandom_range(0, 9) != 0) begin
      pd = 16'($urandom_range(0, 4));
      st = 16'($urandom_range(0, 4));
    end
    if (pick < 30) rq = REQ_TICK;
    else if (pick < 50) rq = REQ_ADD;
    else if (pick < 60) rq = REQ_REMOVE;
    else if (pick < 90) rq = REQ_DISPATCH;
    else if (pick < 95) rq = REQ_SETTIME;
    else rq = 3'($urandom_range(REQ_UNUSED5, REQ_UNUSED7));
    send_word(rq, 3'($urandom), pd, st, $urandom);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed opening: empty list, refusals, wrap, run-once, any-position removal
    send_word(REQ_TICK, 3'd0, 16'h0, 16'h0, 32'h0);
    send_word(REQ_DISPATCH, 3'd0, 16'h0, 16'h0, 32'h0);
    send_word(REQ_REMOVE, 3'd5, 16'h0, 16'h0, 32'h0);
    send_word(REQ_ADD, 3'd0, 16'h0, 16'h0, 32'h0);
    send_word(REQ_ADD, 3'd0, 16'h3, 16'h3, 32'h0);
    send_word(REQ_ADD, 3'd7, 16'hffff, 16'hffff, 32'hffffffff);
    send_word(REQ_ADD, 3'd3, 16'h2, 16'h1, 32'h0);
    send_word(REQ_TICK, 3'd0, 16'h0, 16'h0, 32'h0);
    send_word(REQ_TICK, 3'd0, 16'h0, 16'h0, 32'h0);
    send_word(REQ_DISPATCH, 3'd0, 16'h0, 16'h0, 32'h0);
    send_word(REQ_DISPATCH, 3'd0, 16'h0, 16'h0, 32'h0);
    send_word(REQ_DISPATCH, 3'd0, 16'h0, 16'h0, 32'h0);
    send_word(REQ_REMOVE, 3'd7, 16'h0, 16'h0, 32'h0);
    send_word(REQ_SETTIME, 3'd0, 16'h0, 16'h0, 32'hffffffff);
    send_word(REQ_TICK, 3'd0, 16'h0, 16'h0, 32'h0);
    send_word(REQ_UNUSED5, 3'd7, 16'hffff, 16'hffff, 32'hffffffff);
    send_word(REQ_UNUSED6, 3'd1, 16'h1, 16'h1, 32'h1);
    send_word(REQ_UNUSED7, 3'd0, 16'h0, 16'h0, 32'h0);
    send_word(REQ_ADD, 3'd5, 16'h0, 16'h5, 32'h0);
    send_word(REQ_TICK, 3'd0, 16'h0, 16'h0, 32'h0);
    send_word(REQ_DISPATCH, 3'd0, 16'h0, 16'h0, 32'h0);
    send_word(REQ_REMOVE, 3'd3, 16'h0, 16'h0, 32'h0);
    send_word(REQ_REMOVE, 3'd5, 16'h0, 16'h0, 32'h0);
    send_word(REQ_DISPATCH, 3'd0, 16'h0, 16'h0, 32'h0);

    repeat (RANDOM_WORDS) random_word();
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("periodic_task_dispatcher verification clean");
    else $display("periodic_task_dispatcher verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/pdt_pkg.sv
hw/rtl/pdt_front.sv
hw/rtl/pdt_queue.sv
hw/rtl/pdt_engine.sv
hw/rtl/periodic_task_dispatcher.sv
hw/rtl/pdt_checker.sv
sim/pdt_checker.sv
sim/tb_top.sv
